// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL of the color ramp unit.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CLC_ASSERT(lbl, prop, msg)
`define CLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/clc_pkg.sv =====
// Shared types and constants of the piecewise linear color ramp unit.
// Used by the stop cells, the interpolator and the top level.
`default_nettype none
package clc_pkg;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned COL_W           = 16;
  localparam int unsigned NUM_CH          = 4;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned CNT_REG_W       = 4;
  localparam int unsigned MAX_STOPS_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned IN_TDATA_W      = 88;
  localparam int unsigned OUT_TDATA_W     = 64;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_STOPS_IN_USE = 3'd0;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef logic [NUM_CH-1:0][COL_W-1:0] rgba_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    rgba_t            col;
  } stop_t;

  // Sample token that walks down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             interp;
    logic             clamp_hi;
    logic [POS_W-1:0] t;
    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] hi_pos;
    rgba_t            lo_col;
    rgba_t            hi_col;
  } tok_t;
endpackage
`default_nettype wire

// ===== rtl/clc_cell.sv =====
// One color stop cell: stores one stop and registers the passing sample token.
// Depends on clc_pkg.
`default_nettype none
module clc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned NW       = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire clc_pkg::stop_t wr_stop_i,
  input  wire logic [NW-1:0]  n_i,
  input  wire logic [clc_pkg::POS_W-1:0] last_pos_i,
  input  wire clc_pkg::stop_t prev_stop_i,
  input  wire clc_pkg::tok_t  tok_i,
  output clc_pkg::stop_t      stop_o,
  output clc_pkg::tok_t       tok_o
);
  localparam logic IS_FIRST = (CELL_IDX == 0);
  localparam logic [NW-1:0] NEXT_IDX = NW'(CELL_IDX + 1);

  clc_pkg::stop_t stop_q;
  clc_pkg::tok_t  tok_d, tok_q;
  logic           valid_q;
  logic           is_last;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stop_q <= wr_stop_i;
    end
  end

  assign is_last = (n_i == NEXT_IDX);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found) begin
      if (IS_FIRST) begin
        if (n_i == '0) begin
          tok_d.found  = 1'b1;
          tok_d.interp = 1'b0;
          tok_d.lo_col = '0;
        end else if (tok_i.t <= stop_q.pos) begin
          tok_d.found  = 1'b1;
          tok_d.interp = 1'b0;
          tok_d.lo_col = stop_q.col;
        end else if (tok_i.t >= last_pos_i) begin
          tok_d.clamp_hi = 1'b1;
        end
      end
      // At or above the last stop: the last cell hands out its own color.
      if (!tok_d.found && tok_d.clamp_hi && is_last) begin
        tok_d.found  = 1'b1;
        tok_d.interp = 1'b0;
        tok_d.lo_col = stop_q.col;
      end else if (!tok_d.found && !tok_d.clamp_hi && !IS_FIRST &&
                   (tok_i.t <= stop_q.pos || is_last)) begin
        tok_d.found  = 1'b1;
        tok_d.interp = 1'b1;
        tok_d.lo_pos = prev_stop_i.pos;
        tok_d.lo_col = prev_stop_i.col;
        tok_d.hi_pos = stop_q.pos;
        tok_d.hi_col = stop_q.col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign stop_o = stop_q;
endmodule
`default_nettype wire

// ===== rtl/clc_lerp.sv =====
// Interpolator: serial weight divider, channel multiply, blend and output register.
// Depends on clc_pkg.
`default_nettype none
module clc_lerp #(
  parameter int unsigned FRAC_BITS = clc_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire clc_pkg::tok_t tok_i,
  output logic               done_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output clc_pkg::rgba_t     out_col_o
);
  localparam int unsigned W_W   = FRAC_BITS + 1;
  localparam int unsigned CW    = $clog2(FRAC_BITS + 1);
  localparam int unsigned P_W   = clc_pkg::COL_W + W_W;
  localparam int unsigned POS_W = clc_pkg::POS_W;
  localparam int unsigned COL_W = clc_pkg::COL_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SUM  = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [POS_W:0]   rem_q, rem_d;
  logic [POS_W-1:0] den_q, den_d;
  logic [W_W-1:0]   w_q, w_d;
  clc_pkg::rgba_t   lo_q, lo_d, hi_q, hi_d, res_q, res_d;
  logic [clc_pkg::NUM_CH-1:0][P_W-1:0] prod_q, prod_d;
  logic [clc_pkg::NUM_CH-1:0] neg_q, neg_d;
  logic             out_valid_q;
  clc_pkg::rgba_t   out_col_q;
  logic             ge;
  logic [POS_W:0]   rem_sub;
  logic             load_out;

  assign ge       = (rem_q >= {1'b0, den_q});
  assign rem_sub  = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign load_out = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    w_d     = w_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    res_d   = res_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    case (state_q)
      S_IDLE: begin
        if (tok_i.valid) begin
          lo_d = tok_i.lo_col;
          hi_d = tok_i.hi_col;
          if (tok_i.interp) begin
            rem_d   = {1'b0, tok_i.t - tok_i.lo_pos};
            den_d   = tok_i.hi_pos - tok_i.lo_pos;
            w_d     = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            res_d   = tok_i.lo_col;
            state_d = S_HOLD;
          end
        end
      end
      S_DIV: begin
        // One quotient bit per cycle, most significant first.
        w_d   = {w_q[W_W-2:0], ge};
        rem_d = {rem_sub[POS_W-1:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(FRAC_BITS)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        for (int c = 0; c < clc_pkg::NUM_CH; c++) begin
          neg_d[c]  = hi_q[c] < lo_q[c];
          prod_d[c] = P_W'(neg_d[c] ? (lo_q[c] - hi_q[c]) : (hi_q[c] - lo_q[c])) *
                      P_W'(w_q);
        end
        state_d = S_SUM;
      end
      S_SUM: begin
        for (int c = 0; c < clc_pkg::NUM_CH; c++) begin
          res_d[c] = neg_q[c] ? (lo_q[c] - prod_q[c][FRAC_BITS +: COL_W])
                              : (lo_q[c] + prod_q[c][FRAC_BITS +: COL_W]);
        end
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    w_q    <= w_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    if (load_out) begin
      out_col_q <= res_q;
    end
  end

  assign done_o      = load_out;
  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
endmodule
`default_nettype wire

// ===== rtl/rgba_colormap_piecewise_lerp_unit.sv =====
// Piecewise linear RGBA color ramp. A stop write is accepted whenever no sample is in flight.
// A sample walks the MAX_STOPS stop cells, each of which registers it. A sample that needs
// no interpolation goes from the chain to the output register; an interpolated one also passes
// the bit serial weight divider, multiply and blend. One sample is in flight at a time; the next
// item is accepted once the result enters the output register. Reset clears control state and
// stops_in_use only.
`default_nettype none
`include "assert_macros.svh"
module rgba_colormap_piecewise_lerp_unit #(
  parameter int unsigned MAX_STOPS = clc_pkg::MAX_STOPS_DEF,
  parameter int unsigned FRAC_BITS = clc_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // position[15:0], stop_index[18:16], in_red[34:19], in_green[50:35],
  // in_blue[66:51], in_alpha[82:67], zero fill [87:83]
  input  wire logic [clc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // kind[0]
  input  wire logic s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
  output logic [clc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [clc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned NW = $clog2(MAX_STOPS + 1);
  localparam int unsigned IW = $clog2(MAX_STOPS);

  logic [clc_pkg::CNT_REG_W-1:0] stops_q;
  logic [NW-1:0]                 n_eff, n_m1;
  logic                          busy_q;
  logic                          accept, wr_en, done;
  logic [clc_pkg::IDX_W-1:0]     wr_idx;
  clc_pkg::stop_t                wr_stop;
  clc_pkg::stop_t                stops [MAX_STOPS];
  clc_pkg::tok_t                 toks  [MAX_STOPS+1];
  logic [MAX_STOPS-1:0]          tok_valid;
  logic [clc_pkg::POS_W-1:0]     last_pos;
  clc_pkg::rgba_t                out_col;

  assign pready = 1'b1;
  assign prdata = (paddr == clc_pkg::ADDR_STOPS_IN_USE) ? 32'(stops_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stops_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == clc_pkg::ADDR_STOPS_IN_USE) begin
      stops_q <= pwdata[clc_pkg::CNT_REG_W-1:0];
    end
  end

  always_comb begin
    if (32'(stops_q) > MAX_STOPS) begin
      n_eff = NW'(MAX_STOPS);
    end else begin
      n_eff = NW'(stops_q);
    end
  end
  assign n_m1     = n_eff - 1'b1;
  assign last_pos = stops[n_m1[IW-1:0]].pos;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_idx        = s_axis_tdata[18:16];
  assign wr_en         = accept && (s_axis_tuser == clc_pkg::KIND_WRITE) &&
                         (32'(wr_idx) < MAX_STOPS);
  assign wr_stop.pos   = s_axis_tdata[15:0];
  assign wr_stop.col   = {s_axis_tdata[82:67], s_axis_tdata[66:51],
                          s_axis_tdata[50:35], s_axis_tdata[34:19]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept && s_axis_tuser == clc_pkg::KIND_SAMPLE) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_comb begin
    toks[0]          = '0;
    toks[0].valid    = accept && (s_axis_tuser == clc_pkg::KIND_SAMPLE);
    toks[0].t        = s_axis_tdata[15:0];
  end

  for (genvar g = 0; g < MAX_STOPS; g++) begin : g_cell
    clc_cell #(
      .CELL_IDX (g),
      .NW       (NW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (wr_en && (32'(wr_idx) == g)),
      .wr_stop_i   (wr_stop),
      .n_i         (n_eff),
      .last_pos_i  (last_pos),
      .prev_stop_i (stops[(g == 0) ? 0 : g - 1]),
      .tok_i       (toks[g]),
      .stop_o      (stops[g]),
      .tok_o       (toks[g+1])
    );
    assign tok_valid[g] = toks[g+1].valid;
  end

  clc_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (toks[MAX_STOPS]),
    .done_o      (done),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_col_o   (out_col)
  );

  assign m_axis_tdata = out_col;

  `CLC_ASSERT(a_single_token, $countones(tok_valid) <= 1, "more than one sample in the chain")
  `CLC_ASSERT(a_done_busy, done |-> busy_q, "result produced with no sample in flight")
  `CLC_ASSERT(a_rise_busy, $rose(m_axis_tvalid) |-> $past(busy_q), "result without a sample")
  `CLC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !busy_q || rst_ni, "busy out of reset")
endmodule
`default_nettype wire
